[rtl/core/rtbh_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rtbh_pkg: shared constants, types and tables for the transform bin hash
// Widths, pipeline depths, angle constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package rtbh_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int TAB_LEN       = 24;
    localparam int ISQ_STEPS     = 15;
    localparam int CORD_LAT      = CORDIC_STAGES + 2;
    localparam int DIV_NW        = 25;
    localparam int DIV_DW        = 17;
    localparam int DIV_STEPS     = DIV_NW;

    localparam int P_COR = 1 + ISQ_STEPS;
    localparam int P_NUM = P_COR + CORD_LAT;
    localparam int P_OUT = P_NUM + 1 + DIV_STEPS;
    localparam int LAT   = P_OUT + 1;

    localparam int IN_W = 17;
    localparam int XY_W = 32;
    localparam int Z_W  = 27;

    localparam logic signed [Z_W-1:0] DEG_FULL    = 27'sd23592960;
    localparam logic signed [Z_W-1:0] DEG_HALF    = 27'sd11796480;
    localparam logic signed [Z_W-1:0] DEG_QUARTER = 27'sd5898240;
    localparam logic signed [Z_W-1:0] DEG_3QUART  = 27'sd17694720;

    localparam logic [15:0] ANG_FULL_Q7 = 16'd46080;
    localparam logic [15:0] ANG_HALF_Q7 = 16'd23040;
    localparam logic [17:0] ANG_WRAP2   = 18'd92160;

    localparam logic [19:0] TBIN_MAX = 20'hFFFFF;
    localparam logic [15:0] ABIN_MAX = 16'hFFFF;

    localparam logic [7:0] CH_HELIX  = 8'h48;
    localparam logic [7:0] CH_STRAND = 8'h45;

    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_CELL_WIDTH  = 2'd0;
    localparam reg_idx_t REG_ANGLE_WIDTH = 2'd1;
    localparam reg_idx_t REG_USE_PAIR    = 2'd2;

    typedef struct packed {
        logic signed [15:0] r20;
        logic signed [15:0] r21;
        logic signed [15:0] r02;
        logic signed [15:0] r12;
        logic signed [15:0] c;
        logic               vert;
        logic               vneg;
        logic [2:0][24:0]   tmag;
        logic [2:0]         tsign;
        logic [3:0]         pair;
    } side_t;

    typedef struct packed {
        logic [2:0] tsign;
        logic [3:0] pair;
    } tail_t;

    localparam logic signed [Z_W-1:0] ATAN_TAB [TAB_LEN] = '{
        27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945, 27'sd234379, 27'sd117304,
        27'sd58666, 27'sd29335, 27'sd14668, 27'sd7334, 27'sd3667, 27'sd1833,
        27'sd917, 27'sd458, 27'sd229, 27'sd115, 27'sd57, 27'sd29,
        27'sd14, 27'sd7, 27'sd4, 27'sd2, 27'sd1, 27'sd0
    };

    function automatic logic [1:0] struct_code(input logic [7:0] ch);
        logic [1:0] code;
        case (ch)
            CH_HELIX:  code = 2'd0;
            CH_STRAND: code = 2'd1;
            default:   code = 2'd2;
        endcase
        return code;
    endfunction

endpackage
`default_nettype wire

[rtl/core/rtbh_cordic.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rtbh_cordic: pipelined vectoring CORDIC atan2 in degrees
// One stage per rotation, then wrap into [0, 360) and round to Q.7 degrees.
// ----------------------------------------------------------------------------
module rtbh_cordic import rtbh_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   adv,
    input  wire logic signed [IN_W-1:0] y_in,
    input  wire logic signed [IN_W-1:0] x_in,
    output logic [15:0]                 ang_q7
);

    logic signed [XY_W-1:0] x_reg [0:CORDIC_STAGES];
    logic signed [XY_W-1:0] y_reg [0:CORDIC_STAGES];
    logic signed [Z_W-1:0]  z_reg [0:CORDIC_STAGES];
    logic                   skip_reg [0:CORDIC_STAGES];
    logic [15:0]            q7_reg;

    logic signed [XY_W-1:0] x0_next, y0_next, xe, ye;
    logic signed [Z_W-1:0]  z0_next;
    logic                   skip0_next;

    always_comb begin
        xe         = XY_W'(x_in);
        ye         = XY_W'(y_in);
        x0_next    = xe <<< 12;
        y0_next    = ye <<< 12;
        z0_next    = '0;
        skip0_next = 1'b0;
        if (y_in == '0) begin
            skip0_next = 1'b1;
            z0_next    = (x_in < 0) ? DEG_HALF : '0;
        end else if (x_in == '0) begin
            skip0_next = 1'b1;
            z0_next    = (y_in > 0) ? DEG_QUARTER : DEG_3QUART;
        end else if (x_in < 0) begin
            x0_next = (-xe) <<< 12;
            y0_next = (-ye) <<< 12;
            z0_next = DEG_HALF;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x_reg[0]    <= x0_next;
            y_reg[0]    <= y0_next;
            z_reg[0]    <= z0_next;
            skip_reg[0] <= skip0_next;
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
        logic signed [XY_W-1:0] dx, dy, x_next, y_next;
        logic signed [Z_W-1:0]  z_next;
        always_comb begin
            dx = y_reg[i] >>> i;
            dy = x_reg[i] >>> i;
            if (!y_reg[i][XY_W-1]) begin
                x_next = x_reg[i] + dx;
                y_next = y_reg[i] - dy;
                z_next = z_reg[i] + ATAN_TAB[i];
            end else begin
                x_next = x_reg[i] - dx;
                y_next = y_reg[i] + dy;
                z_next = z_reg[i] - ATAN_TAB[i];
            end
            if (skip_reg[i]) begin
                z_next = z_reg[i];
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                x_reg[i+1]    <= x_next;
                y_reg[i+1]    <= y_next;
                z_reg[i+1]    <= z_next;
                skip_reg[i+1] <= skip_reg[i];
            end
        end
    end

    logic signed [Z_W-1:0] zw, zr;
    logic [15:0]           q7_next;

    always_comb begin
        zw = z_reg[CORDIC_STAGES];
        if (zw < 0) begin
            zw = zw + DEG_FULL;
        end else if (zw >= DEG_FULL) begin
            zw = zw - DEG_FULL;
        end
        zr      = zw + 27'sd256;
        q7_next = zr[24:9];
        if (q7_next >= ANG_FULL_Q7) begin
            q7_next = q7_next - ANG_FULL_Q7;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            q7_reg <= q7_next;
        end
    end

    assign ang_q7 = q7_reg;

endmodule
`default_nettype wire

[rtl/core/rtbh_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rtbh_div: pipelined restoring divider
// One quotient bit per stage; the divisor must be held steady while items flow, the block does not enforce it.
// ----------------------------------------------------------------------------
module rtbh_div import rtbh_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              adv,
    input  wire logic [DIV_NW-1:0] dividend,
    input  wire logic [DIV_DW-1:0] divisor,
    output logic [DIV_NW-1:0]      quot
);

    logic [DIV_DW-1:0] rem_reg [0:DIV_STEPS-1];
    logic [DIV_NW-1:0] nq_reg  [0:DIV_STEPS-1];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [DIV_DW-1:0] rem_in, rem_next;
        logic [DIV_NW-1:0] nq_in, nq_next;
        logic [DIV_DW:0]   trial;
        logic              ge;
        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign nq_in  = dividend;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign nq_in  = nq_reg[k-1];
        end
        always_comb begin
            trial    = {rem_in, nq_in[DIV_NW-1]};
            ge       = trial >= {1'b0, divisor};
            rem_next = ge ? DIV_DW'(trial - {1'b0, divisor}) : trial[DIV_DW-1:0];
            nq_next  = {nq_in[DIV_NW-2:0], ge};
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[k] <= rem_next;
                nq_reg[k]  <= nq_next;
            end
        end
    end

    assign quot = nq_reg[DIV_STEPS-1];

endmodule
`default_nettype wire

[rtl/core/rigid_transform_bin_hash.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rigid_transform_bin_hash: rigid transform to 63-bit bin key
// Euler angles by CORDIC, translation and angle binning, XOR key packing.
// ----------------------------------------------------------------------------
// Accepts one transform per clock when not stalled and returns one key per transform, in order.
// The pipeline has one input stage, 15 square-root stages, 18 CORDIC
// stages, one numerator stage, 25 divider stages and the output register.
// The whole pipeline advances when the output register is empty or taken.
module rigid_transform_bin_hash import rtbh_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [15:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // rot_00, rot_02, rot_12, rot_20, rot_21, rot_22 (16 each), trans_x,
    // trans_y, trans_z (24 each), struct_first, struct_second (8 each)
    input  wire logic [183:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // bin_key [62:0], zero [63]
    output logic [63:0]       m_tdata
);

    logic [15:0] cell_width_reg, angle_width_reg;
    logic        use_pair_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_width_reg  <= 16'd256;
            angle_width_reg <= 16'd1280;
            use_pair_reg    <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_CELL_WIDTH:  cell_width_reg  <= cfg_wdata;
                REG_ANGLE_WIDTH: angle_width_reg <= cfg_wdata;
                REG_USE_PAIR:    use_pair_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    logic [15:0] cw_eff, aw_eff;
    assign cw_eff = (cell_width_reg == '0) ? 16'd1 : cell_width_reg;
    assign aw_eff = (angle_width_reg == '0) ? 16'd1 : angle_width_reg;

    logic           adv;
    logic [LAT-1:0] vld_reg;

    assign adv      = !vld_reg[LAT-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    logic signed [15:0] r00, r02, r12, r20, r21, r22;
    logic signed [23:0] trans [3];
    assign r00      = s_tdata[15:0];
    assign r02      = s_tdata[31:16];
    assign r12      = s_tdata[47:32];
    assign r20      = s_tdata[63:48];
    assign r21      = s_tdata[79:64];
    assign r22      = s_tdata[95:80];
    assign trans[0] = s_tdata[119:96];
    assign trans[1] = s_tdata[143:120];
    assign trans[2] = s_tdata[167:144];

    side_t              side_next;
    side_t              side_reg [0:P_NUM-1];
    logic signed [15:0] c_raw;
    logic signed [31:0] csq;
    logic [28:0]        rad_next;
    logic [2:0][24:0]   tmag_w;

    for (genvar a = 0; a < 3; a++) begin : g_tnum
        logic signed [25:0] tn;
        logic [25:0]        tneg;
        assign tn        = $signed({trans[a][23], trans[a], 1'b0}) + $signed({10'd0, cw_eff});
        assign tneg      = 26'(-tn);
        assign tmag_w[a] = tn[25] ? tneg[24:0] : tn[24:0];
    end

    always_comb begin
        side_next.r20  = r20;
        side_next.r21  = r21;
        side_next.r02  = r02;
        side_next.r12  = r12;
        side_next.vert = (r22 >= 16'sd16384) || (r22 <= -16'sd16384);
        side_next.vneg = r22[15];
        c_raw          = side_next.vert ? r00 : r22;
        if (c_raw > 16'sd16384) begin
            side_next.c = 16'sd16384;
        end else if (c_raw < -16'sd16384) begin
            side_next.c = -16'sd16384;
        end else begin
            side_next.c = c_raw;
        end
        side_next.tmag  = tmag_w;
        side_next.tsign = {trans[2][23], trans[1][23], trans[0][23]};
        side_next.pair  = 4'(struct_code(s_tdata[175:168])) * 4'd3
                        + 4'(struct_code(s_tdata[183:176]));
    end

    assign csq      = side_next.c * side_next.c;
    assign rad_next = 29'(32'sd268435456 - csq);

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= side_next;
            for (int i = 1; i < P_NUM; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    logic [28:0] isq_rem_reg [0:ISQ_STEPS];
    logic [28:0] isq_res_reg [0:ISQ_STEPS];

    always_ff @(posedge aclk) begin
        if (adv) begin
            isq_rem_reg[0] <= rad_next;
            isq_res_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_isq
        localparam logic [28:0] BIT = 29'(1) << (2 * (ISQ_STEPS - 1 - k));
        logic [28:0] trial;
        logic        ge;
        assign trial = isq_res_reg[k] + BIT;
        assign ge    = isq_rem_reg[k] >= trial;
        always_ff @(posedge aclk) begin
            if (adv) begin
                isq_rem_reg[k+1] <= ge ? isq_rem_reg[k] - trial : isq_rem_reg[k];
                isq_res_reg[k+1] <= ge ? (isq_res_reg[k] >> 1) + BIT : isq_res_reg[k] >> 1;
            end
        end
    end

    side_t                  sc;
    logic signed [IN_W-1:0] sq, cy [3], cx [3];
    logic [15:0]            ang [3];

    assign sc    = side_reg[P_COR-1];
    assign sq    = {1'b0, isq_res_reg[ISQ_STEPS][15:0]};
    assign cy[0] = sc.vert ? sq : IN_W'(sc.r20);
    assign cx[0] = sc.vert ? IN_W'(sc.c) : -IN_W'(sc.r21);
    assign cy[1] = IN_W'(sc.r02);
    assign cx[1] = IN_W'(sc.r12);
    assign cy[2] = sq;
    assign cx[2] = IN_W'(sc.c);

    for (genvar u = 0; u < 3; u++) begin : g_cor
        rtbh_cordic u_cordic (
            .aclk   (aclk),
            .adv    (adv),
            .y_in   (cy[u]),
            .x_in   (cx[u]),
            .ang_q7 (ang[u])
        );
    end

    side_t       sn;
    logic [15:0] e_q7 [3];
    logic [DIV_NW-1:0] num_reg [6];
    tail_t       tail_reg [0:DIV_STEPS];

    assign sn      = side_reg[P_NUM-1];
    assign e_q7[0] = ang[0];
    assign e_q7[1] = sn.vert ? 16'd0 : ang[1];
    assign e_q7[2] = sn.vert ? (sn.vneg ? ANG_HALF_Q7 : 16'd0) : ang[2];

    for (genvar a = 0; a < 3; a++) begin : g_anum
        logic [17:0] v, v_next;
        assign v      = {1'b0, e_q7[a], 1'b0} + {2'b0, aw_eff};
        assign v_next = (v >= ANG_WRAP2) ? v - ANG_WRAP2 : v;
        always_ff @(posedge aclk) begin
            if (adv) begin
                num_reg[a]     <= sn.tmag[a];
                num_reg[a + 3] <= DIV_NW'(v_next);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tail_reg[0] <= '{tsign: sn.tsign, pair: sn.pair};
            for (int i = 1; i <= DIV_STEPS; i++) begin
                tail_reg[i] <= tail_reg[i-1];
            end
        end
    end

    logic [DIV_NW-1:0] quot [6];
    logic [DIV_DW-1:0] tdiv, adiv;
    assign tdiv = {cw_eff, 1'b0};
    assign adiv = {aw_eff, 1'b0};

    for (genvar d = 0; d < 6; d++) begin : g_div
        rtbh_div u_div (
            .aclk     (aclk),
            .adv      (adv),
            .dividend (num_reg[d]),
            .divisor  ((d < 3) ? tdiv : adiv),
            .quot     (quot[d])
        );
    end

    logic [19:0] tb [3];
    logic [15:0] ab [3];
    logic [62:0] key_next, key_reg;
    tail_t       tl;

    assign tl = tail_reg[DIV_STEPS];

    for (genvar a = 0; a < 3; a++) begin : g_sat
        assign tb[a] = (quot[a][24:20] != '0) ? TBIN_MAX : quot[a][19:0];
        assign ab[a] = (quot[a + 3][24:16] != '0) ? ABIN_MAX : quot[a + 3][15:0];
    end

    always_comb begin
        key_next = 63'(tb[0]) ^ (63'(tb[1]) << 8) ^ (63'(tb[2]) << 16)
                 ^ (63'(ab[0]) << 24) ^ (63'(ab[1]) << 34) ^ (63'(ab[2]) << 44)
                 ^ (63'(tl.tsign) << 60);
        if (use_pair_reg) begin
            key_next = key_next ^ (63'(tl.pair) << 54);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            key_reg <= key_next;
        end
    end

    assign m_tdata = {1'b0, key_reg};

endmodule
`default_nettype wire

[rtl/core/rtbh_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rtbh_checker: port-level checks for the transform bin hash
// Watches the stream ports of the top level; bound to it below.
// ----------------------------------------------------------------------------
module rtbh_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[63] == 1'b0)
        else $error("key padding bit set");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind rigid_transform_bin_hash rtbh_checker u_rtbh_checker (.*);
`default_nettype wire
